>>> src/cbe_pkg.sv
// shared constants for the cubic bezier point evaluator
package cbe_pkg;

  // width of the point count and point index fields
  localparam int CNT_W = 15;

  // guard bits above the coordinate width for the horner accumulators
  localparam int COEF_GUARD = 6;

  // register stages of the horner evaluation after t is known
  localparam int HORNER_STAGES = 6;

endpackage

>>> src/cbe_div.sv
// pipelined restoring divider forming t = index / (count - 1) in fixed point
module cbe_div #(
  parameter int TF = 16
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [cbe_pkg::CNT_W-1:0] point_count,
  input  logic [cbe_pkg::CNT_W-1:0] point_index,
  output logic [TF:0]               t,
  output logic                      clamp
);
  import cbe_pkg::*;

  localparam int L = TF + 1;

  logic [CNT_W-1:0] idx0;
  logic [CNT_W-1:0] dv     [0:L];
  logic [CNT_W-1:0] rem    [1:L];
  logic [TF:0]      quo    [1:L];
  logic             clamp_s[0:L];
  logic             tzero_s[0:L];

  logic             ge1;

  // stage 0: divisor and special cases
  always_ff @(posedge clk) begin
    if (en) begin
      idx0       <= point_index;
      dv[0]      <= point_count - CNT_W'(1);
      clamp_s[0] <= point_index >= point_count;
      tzero_s[0] <= point_count == CNT_W'(1);
    end
  end

  // stage 1: integer bit of the quotient
  assign ge1 = idx0 >= dv[0];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[1]     <= ge1 ? idx0 - dv[0] : idx0;
      quo[1]     <= {TF'(0), ge1};
      dv[1]      <= dv[0];
      clamp_s[1] <= clamp_s[0];
      tzero_s[1] <= tzero_s[0];
    end
  end

  // one fraction bit per stage
  for (genvar k = 2; k <= L; k++) begin : g_step
    logic [CNT_W:0]   shl;
    logic             ge;
    logic [CNT_W-1:0] rem_next;
    logic [TF:0]      quo_next;

    assign shl      = {rem[k-1], 1'b0};
    assign ge       = shl >= {1'b0, dv[k-1]};
    assign rem_next = ge ? CNT_W'(shl - {1'b0, dv[k-1]}) : shl[CNT_W-1:0];

    if (k == L) begin : g_last
      always_comb begin
        if (clamp_s[k-1]) begin
          quo_next = {1'b1, TF'(0)};
        end else if (tzero_s[k-1]) begin
          quo_next = '0;
        end else begin
          quo_next = {quo[k-1][TF-1:0], ge};
        end
      end
    end else begin : g_mid
      assign quo_next = {quo[k-1][TF-1:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]     <= rem_next;
        quo[k]     <= quo_next;
        dv[k]      <= dv[k-1];
        clamp_s[k] <= clamp_s[k-1];
        tzero_s[k] <= tzero_s[k-1];
      end
    end
  end

  assign t     = quo[L];
  assign clamp = clamp_s[L];

endmodule

>>> src/cbe_axis.sv
// one coordinate axis: coefficients, alignment delay and horner evaluation
module cbe_axis #(
  parameter int COORD_BITS = 12,
  parameter int TF         = 16
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [COORD_BITS-1:0] p0,
  input  logic [COORD_BITS-1:0] p1,
  input  logic [COORD_BITS-1:0] p2,
  input  logic [COORD_BITS-1:0] p3,
  input  logic [TF:0]           t,
  output logic [COORD_BITS-1:0] pos
);
  import cbe_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int W  = CB + COEF_GUARD;
  localparam int PW = W + TF + 2;
  localparam int L  = TF + 1;

  logic signed [CB:0]   d10, d21, d30;
  logic signed [W-1:0]  a_s [1:L];
  logic signed [W-1:0]  b_s [1:L];
  logic signed [W-1:0]  c_s [1:L];
  logic [CB-1:0]        p0_s[0:L];

  logic signed [W-1:0]  x10, x21, x30, x2110;

  logic signed [PW-1:0] m1, m2, m3;
  logic signed [W-1:0]  s1, s2;
  logic [TF:0]          th0, th1, th2, th3;
  logic signed [W-1:0]  bh0, ch0, ch1, ch2;
  logic [CB-1:0]        ph0, ph1, ph2, ph3, ph4;
  logic signed [W-1:0]  fsum;
  logic [CB-1:0]        pos_next;

  // stage 0: point differences
  always_ff @(posedge clk) begin
    if (en) begin
      d10     <= $signed({1'b0, p1}) - $signed({1'b0, p0});
      d21     <= $signed({1'b0, p2}) - $signed({1'b0, p1});
      d30     <= $signed({1'b0, p3}) - $signed({1'b0, p0});
      p0_s[0] <= p0;
    end
  end

  // stage 1: c = 3(p1-p0), b = 3(p2-p1) - c, a = p3 - p0 - 3(p2-p1)
  assign x10   = W'(d10);
  assign x21   = W'(d21);
  assign x30   = W'(d30);
  assign x2110 = x21 - x10;

  always_ff @(posedge clk) begin
    if (en) begin
      c_s[1]  <= x10 + (x10 <<< 1);
      b_s[1]  <= x2110 + (x2110 <<< 1);
      a_s[1]  <= x30 - (x21 + (x21 <<< 1));
      p0_s[1] <= p0_s[0];
    end
  end

  // wait for the divider
  for (genvar k = 2; k <= L; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en) begin
        a_s[k]  <= a_s[k-1];
        b_s[k]  <= b_s[k-1];
        c_s[k]  <= c_s[k-1];
        p0_s[k] <= p0_s[k-1];
      end
    end
  end

  // horner: each multiply, and each floor and add, in its own stage; the last sum saturates into pos
  assign fsum = W'($signed({1'b0, ph4})) + $signed(m3[TF +: W]);

  always_comb begin
    if (fsum[W-1]) begin
      pos_next = '0;
    end else if (|fsum[W-2:CB]) begin
      pos_next = '1;
    end else begin
      pos_next = fsum[CB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1  <= PW'(a_s[L]) * PW'($signed({1'b0, t}));
      th0 <= t;
      bh0 <= b_s[L];
      ch0 <= c_s[L];
      ph0 <= p0_s[L];

      s1  <= $signed(m1[TF +: W]) + bh0;
      th1 <= th0;
      ch1 <= ch0;
      ph1 <= ph0;

      m2  <= PW'(s1) * PW'($signed({1'b0, th1}));
      th2 <= th1;
      ch2 <= ch1;
      ph2 <= ph1;

      s2  <= $signed(m2[TF +: W]) + ch2;
      th3 <= th2;
      ph3 <= ph2;

      m3  <= PW'(s2) * PW'($signed({1'b0, th3}));
      ph4 <= ph3;

      pos <= pos_next;
    end
  end

endmodule

>>> src/cubic_bezier_point_evaluator.sv
// top level of the cubic bezier point evaluator
//
// input channel: in_valid / in_stall with four control points, a point count
// and a point index; output channel: out_valid / out_stall with the curve
// point x_pos, y_pos and index_clamped.
// one item is taken every cycle while in_stall is low; the pipeline is the
// divider for t, one quotient bit per stage, followed by six stages of horner
// evaluation with a register after each multiply, then the output register.
// an index at or above the count yields the end point with index_clamped
// set; a count of one with index zero yields the start point.
// reset empties the pipeline, the output register and the skid register.
// when the receiver stalls, the held item stays on the outputs, the next one
// finished goes to a skid register, and only then is in_stall raised; the
// whole pipeline holds while in_stall is high and nothing is lost.
module cubic_bezier_point_evaluator #(
  parameter int COORD_BITS      = 12,
  parameter int T_FRACTION_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [COORD_BITS-1:0]     p0_x,
  input  logic [COORD_BITS-1:0]     p0_y,
  input  logic [COORD_BITS-1:0]     p1_x,
  input  logic [COORD_BITS-1:0]     p1_y,
  input  logic [COORD_BITS-1:0]     p2_x,
  input  logic [COORD_BITS-1:0]     p2_y,
  input  logic [COORD_BITS-1:0]     p3_x,
  input  logic [COORD_BITS-1:0]     p3_y,
  input  logic [cbe_pkg::CNT_W-1:0] point_count,
  input  logic [cbe_pkg::CNT_W-1:0] point_index,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [COORD_BITS-1:0]     x_pos,
  output logic [COORD_BITS-1:0]     y_pos,
  output logic                      index_clamped
);
  import cbe_pkg::*;

  localparam int DSTG = T_FRACTION_BITS + 2;
  localparam int N    = DSTG + HORNER_STAGES;

  logic                  adv;
  logic                  take;
  logic                  vld [0:N-1];
  logic                  cl  [0:HORNER_STAGES-1];
  logic [T_FRACTION_BITS:0] t;
  logic                  div_clamp;
  logic [COORD_BITS-1:0] px, py;
  logic                  skid_vld;
  logic [COORD_BITS-1:0] skid_x, skid_y;
  logic                  skid_cl;

  assign adv      = !skid_vld;
  assign in_stall = skid_vld;
  assign take     = out_valid && !out_stall;

  cbe_div #(
    .TF (T_FRACTION_BITS)
  ) u_div (
    .clk         (clk),
    .en          (adv),
    .point_count (point_count),
    .point_index (point_index),
    .t           (t),
    .clamp       (div_clamp)
  );

  cbe_axis #(
    .COORD_BITS (COORD_BITS),
    .TF         (T_FRACTION_BITS)
  ) u_axis_x (
    .clk (clk),
    .en  (adv),
    .p0  (p0_x),
    .p1  (p1_x),
    .p2  (p2_x),
    .p3  (p3_x),
    .t   (t),
    .pos (px)
  );

  cbe_axis #(
    .COORD_BITS (COORD_BITS),
    .TF         (T_FRACTION_BITS)
  ) u_axis_y (
    .clk (clk),
    .en  (adv),
    .p0  (p0_y),
    .p1  (p1_y),
    .p2  (p2_y),
    .p3  (p3_y),
    .t   (t),
    .pos (py)
  );

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int i = 1; i < N; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  // clamp flag alongside the horner stages
  always_ff @(posedge clk) begin
    if (adv) begin
      cl[0] <= div_clamp;
      for (int i = 1; i < HORNER_STAGES; i++) begin
        cl[i] <= cl[i-1];
      end
    end
  end

  // output register and skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_vld  <= 1'b0;
    end else if (skid_vld) begin
      if (take) begin
        skid_vld <= 1'b0;
      end
    end else if (vld[N-1]) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_vld <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld) begin
      if (take) begin
        x_pos         <= skid_x;
        y_pos         <= skid_y;
        index_clamped <= skid_cl;
      end
    end else if (vld[N-1]) begin
      if (!out_valid || take) begin
        x_pos         <= px;
        y_pos         <= py;
        index_clamped <= cl[HORNER_STAGES-1];
      end else begin
        skid_x  <= px;
        skid_y  <= py;
        skid_cl <= cl[HORNER_STAGES-1];
      end
    end
  end

endmodule

>>> tb/testbench.sv
// testbench for the cubic bezier point evaluator: directed table plus random segments
`timescale 1ns / 1ps

module testbench;
  import cbe_pkg::CNT_W;

  localparam int COORD_W = 12;
  localparam int T_FRAC = 16;
  localparam longint T_ONE = 64'sd1 << T_FRAC;
  localparam int LATENCY = T_FRAC + 9;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 10;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    coord_t p0x, p0y, p1x, p1y, p2x, p2y, p3x, p3y;
    cnt_t   count;
    cnt_t   index;
  } segment_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   clamped;
  } curve_pt_t;

  typedef struct {
    segment_t  seg;
    bit        has_exp;
    curve_pt_t exp_pt;
  } stim_row_t;

  logic   clk;
  logic   rst;
  logic   in_valid;
  logic   in_stall;
  coord_t p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y;
  cnt_t   point_count;
  cnt_t   point_index;
  logic   out_valid;
  logic   out_stall;
  coord_t x_pos, y_pos;
  logic   index_clamped;

  curve_pt_t curve_pts_q[$];
  stim_row_t dir_rows[$];
  bit        cur_has_exp;
  curve_pt_t cur_exp;
  int        idle_pct;
  int        stall_pct;
  bit        hold_req;
  int        hold_left;
  int        err_count;

  cubic_bezier_point_evaluator #(
    .COORD_BITS     (COORD_W),
    .T_FRACTION_BITS(T_FRAC)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .p0_x         (p0_x),
    .p0_y         (p0_y),
    .p1_x         (p1_x),
    .p1_y         (p1_y),
    .p2_x         (p2_x),
    .p2_y         (p2_y),
    .p3_x         (p3_x),
    .p3_y         (p3_y),
    .point_count  (point_count),
    .point_index  (point_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .x_pos        (x_pos),
    .y_pos        (y_pos),
    .index_clamped(index_clamped)
  );

  // floor(v * t / 2^T_FRAC), arithmetic shift floors toward minus infinity
  function automatic longint scale_by_t(input longint v, input longint t);
    return (v * t) >>> T_FRAC;
  endfunction

  function automatic coord_t axis_position(input coord_t q0, input coord_t q1,
                                           input coord_t q2, input coord_t q3,
                                           input longint t);
    longint p0, p1, p2, p3, c, b, a, v;
    p0 = q0;
    p1 = q1;
    p2 = q2;
    p3 = q3;
    c = 3 * (p1 - p0);
    b = 3 * (p2 - p1) - c;
    a = p3 - p0 - c - b;
    v = scale_by_t(a, t);
    v = scale_by_t(v + b, t);
    v = scale_by_t(v + c, t);
    v = p0 + v;
    if (v < 0) v = 0;
    if (v > (1 << COORD_W) - 1) v = (1 << COORD_W) - 1;
    return coord_t'(v);
  endfunction

  function automatic curve_pt_t curve_point(input segment_t s);
    curve_pt_t r;
    longint    t;
    r.clamped = 1'b0;
    if (s.index >= s.count) begin
      t = T_ONE;
      r.clamped = 1'b1;
    end else if (s.count == 1) begin
      t = 0;
    end else begin
      t = (longint'(s.index) << T_FRAC) / longint'(s.count - cnt_t'(1));
    end
    r.x = axis_position(s.p0x, s.p1x, s.p2x, s.p3x, t);
    r.y = axis_position(s.p0y, s.p1y, s.p2y, s.p3y, t);
    return r;
  endfunction

  function automatic segment_t make_segment(input coord_t ax, input coord_t ay,
                                            input coord_t bx, input coord_t by,
                                            input coord_t cx, input coord_t cy,
                                            input coord_t dx, input coord_t dy,
                                            input cnt_t cnt, input cnt_t idx);
    segment_t s;
    s = {ax, ay, bx, by, cx, cy, dx, dy, cnt, idx};
    return s;
  endfunction

  task automatic add_row(input segment_t s, input bit has_exp, input coord_t ex,
                         input coord_t ey, input logic ec);
    stim_row_t row;
    row.seg = s;
    row.has_exp = has_exp;
    row.exp_pt = {ex, ey, ec};
    dir_rows.push_back(row);
  endtask

  function automatic coord_t rand_coord();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return coord_t'($urandom_range(0, (1 << COORD_W) - 1));
  endfunction

  function automatic segment_t rand_segment();
    segment_t s;
    int       r;
    s = {rand_coord(), rand_coord(), rand_coord(), rand_coord(),
         rand_coord(), rand_coord(), rand_coord(), rand_coord(), cnt_t'(0), cnt_t'(0)};
    r = $urandom_range(0, 9);
    if (r <= 5) s.count = cnt_t'($urandom_range(2, 64));
    else if (r == 6) s.count = cnt_t'(1);
    else if (r == 7) s.count = cnt_t'($urandom_range(0, (1 << CNT_W) - 1));
    else s.count = cnt_t'($urandom_range(1000, (1 << CNT_W) - 1));
    if (s.count != 0 && $urandom_range(0, 4) != 0)
      s.index = cnt_t'($urandom_range(0, s.count - 1));
    else
      s.index = cnt_t'($urandom_range(0, (1 << CNT_W) - 1));
    return s;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic offer_segment(input segment_t s, input bit has_exp, input curve_pt_t ex);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    {p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, point_count, point_index} <= s;
    cur_has_exp <= has_exp;
    cur_exp <= ex;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) offer_segment(rand_segment(), 1'b0, '0);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: random stalls, plus a long counted hold-off on request
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      if (cur_has_exp)
        curve_pts_q.push_back(cur_exp);
      else
        curve_pts_q.push_back(curve_point({p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
                                           point_count, point_index}));
    end
  end

  always @(posedge clk) begin
    curve_pt_t want;
    if (!rst && out_valid && !out_stall) begin
      if (curve_pts_q.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("unexpected item: x=%0d y=%0d clamped=%0d", x_pos, y_pos, index_clamped);
      end else begin
        want = curve_pts_q.pop_front();
        if (want.x !== x_pos || want.y !== y_pos || want.clamped !== index_clamped) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("mismatch: expected x=%0d y=%0d clamped=%0d, got x=%0d y=%0d clamped=%0d",
                     want.x, want.y, want.clamped, x_pos, y_pos, index_clamped);
        end
      end
    end
  end

  initial begin
    #2400000;
    $display("FAIL cubic_bezier_point_evaluator");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    {p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, point_count, point_index} = '0;
    cur_has_exp = 1'b0;
    cur_exp = '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b0;
    err_count = 0;

    // start point, end point and clamping cases with known answers
    add_row(make_segment(0, 0, 0, 0, 0, 0, 0, 0, 1, 0), 1, 0, 0, 0);
    add_row(make_segment(4095, 4095, 0, 0, 0, 0, 0, 0, 1, 0), 1, 4095, 4095, 0);
    add_row(make_segment(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 1, 0), 1,
            4095, 4095, 0);
    add_row(make_segment(0, 0, 0, 0, 0, 0, 4095, 4095, 10, 10), 1, 4095, 4095, 1);
    add_row(make_segment(7, 9, 100, 200, 300, 400, 123, 456, 0, 0), 1, 123, 456, 1);
    add_row(make_segment(0, 0, 4095, 4095, 0, 0, 4095, 0, 32767, 32767), 1, 4095, 0, 1);
    add_row(make_segment(4095, 0, 0, 4095, 4095, 0, 0, 4095, 32767, 32766), 1, 0, 4095, 0);
    add_row(make_segment(2048, 1, 4095, 0, 0, 4095, 7, 4000, 32767, 0), 1, 2048, 1, 0);
    add_row(make_segment(1, 2, 3, 4, 5, 6, 4094, 4093, 0, 32767), 1, 4094, 4093, 1);
    add_row(make_segment(10, 20, 30, 40, 50, 60, 70, 80, 2, 1), 1, 70, 80, 0);
    add_row(make_segment(1, 2, 3, 4, 5, 6, 2730, 1365, 1, 1), 1, 2730, 1365, 1);
    add_row(make_segment(1, 2, 3, 4, 5, 6, 1365, 2730, 1, 32767), 1, 1365, 2730, 1);
    // interior points, overshoot and saturation near the coordinate limits
    add_row(make_segment(0, 4095, 4095, 0, 4095, 0, 0, 4095, 3, 1), 0, 0, 0, 0);
    add_row(make_segment(4095, 0, 0, 4095, 0, 4095, 4095, 0, 3, 1), 0, 0, 0, 0);
    add_row(make_segment(0, 0, 4095, 4095, 0, 0, 4095, 4095, 5, 1), 0, 0, 0, 0);
    add_row(make_segment(0, 0, 4095, 4095, 0, 0, 4095, 4095, 5, 2), 0, 0, 0, 0);
    add_row(make_segment(0, 0, 4095, 4095, 0, 0, 4095, 4095, 5, 3), 0, 0, 0, 0);
    add_row(make_segment(0, 4095, 4095, 0, 4095, 0, 0, 4095, 32767, 1), 0, 0, 0, 0);
    add_row(make_segment(0, 4095, 4095, 0, 4095, 0, 0, 4095, 32767, 32765), 0, 0, 0, 0);
    add_row(make_segment(4095, 0, 0, 4095, 0, 4095, 4095, 0, 32767, 16383), 0, 0, 0, 0);
    add_row(make_segment(2730, 1365, 1365, 2730, 2730, 1365, 1365, 2730, 1000, 333),
            0, 0, 0, 0);
    add_row(make_segment(1365, 2730, 2730, 1365, 1365, 2730, 2730, 1365, 21846, 10922),
            0, 0, 0, 0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) offer_segment(dir_rows[i].seg, dir_rows[i].has_exp,
                                        dir_rows[i].exp_pt);

    idle_pct = 0;
    stall_pct = 0;
    run_random(80);
    idle_pct = 81;
    run_random(80);
    idle_pct = 0;
    stall_pct = 81;
    run_random(80);
    idle_pct = 26;
    stall_pct = 26;
    run_random(80);

    // long receiver hold-off while items keep coming, fills the pipeline
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b1;
    run_random(60);

    in_valid <= 1'b0;
    while (curve_pts_q.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);

    if (err_count == 0) begin
      $display("PASS cubic_bezier_point_evaluator");
    end else begin
      $display("FAIL cubic_bezier_point_evaluator");
    end
    $finish;
  end

endmodule
